// ----- rtl/core/rne_pkg.sv -----
// Shared types and constants of the recurrent network evaluator.
// Holds the register map, the action codes and the MAC unit's tag and result structs.
// No dependencies.
package rne_pkg;

	localparam int DEF_INPUT_COUNT  = 8;
	localparam int DEF_OUTPUT_COUNT = 8;
	localparam int DEF_HIDDEN_COUNT = 22;

	// At most this many output nodes are emitted per evaluation.
	localparam int MAX_EMIT    = 8;
	localparam int OUT_INDEX_W = 3;

	localparam int LEVEL_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [LEVEL_W-1:0] BIAS_LEVEL = 16'sd256;

	localparam logic [7:0]                RST_MAX_CYCLES  = 8'd32;
	localparam logic signed [LEVEL_W-1:0] RST_INIT_LEVEL  = 16'sd0;
	localparam logic [14:0]               RST_OUT_LIMIT   = 15'd256;
	localparam logic signed [LEVEL_W-1:0] RST_TRIG_THRESH = 16'sd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_CYCLES        = 2'd0,
		REG_INIT_LEVEL        = 2'd1,
		REG_OUTPUT_LIMIT      = 2'd2,
		REG_TRIGGER_THRESHOLD = 2'd3
	} cfg_reg_t;

	localparam logic ACT_WEIGHT = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Control carried alongside one operand pair into the MAC unit.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_tag_t;

	// Status and row result coming back from the MAC unit.
	typedef struct packed {
		logic                      busy;
		logic                      done;
		logic signed [LEVEL_W-1:0] level;
	} mac_res_t;

endpackage

// ----- rtl/core/rne_mac.sv -----
// Shared multiply-accumulate unit: one product per cycle, summed over one row.
// At the end of a row the sum is rounded to Q8.8 and saturated to 16 bits.
// Depends on rne_pkg.
module rne_mac #(
	parameter int NODE_COUNT = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rne_pkg::mac_tag_t                    tag_s1,
	input  logic signed [rne_pkg::LEVEL_W-1:0]   weight_s1,
	input  logic signed [rne_pkg::LEVEL_W-1:0]   level_s1,
	output rne_pkg::mac_res_t                    res
);
	import rne_pkg::*;

	// Each product fits 31 bits plus sign; a row of NODE_COUNT of them needs the rest.
	localparam int ACC_W = 2 * LEVEL_W + $clog2(NODE_COUNT);
	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(32767);
	localparam logic signed [ACC_W:0] SAT_LO = -(ACC_W+1)'(32768);
	localparam logic signed [ACC_W:0] HALF   = (ACC_W+1)'(128);

	mac_tag_t                      tag_s2;
	logic signed [2*LEVEL_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          done_q;
	logic signed [ACC_W:0]         rnd_sum;
	logic signed [ACC_W:0]         rnd_q8;
	logic signed [LEVEL_W-1:0]     sat_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			done_q <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= weight_s1 * level_s1;
		if (tag_s2.valid) begin
			acc_q <= (tag_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);
		end
	end

	// Adding half an LSB and shifting arithmetically rounds ties toward plus infinity.
	always_comb begin
		rnd_sum = (ACC_W+1)'(acc_q) + HALF;
		rnd_q8  = rnd_sum >>> 8;
		if (rnd_q8 > SAT_HI) begin
			sat_level = 16'sh7fff;
		end else if (rnd_q8 < SAT_LO) begin
			sat_level = -16'sh8000;
		end else begin
			sat_level = rnd_q8[LEVEL_W-1:0];
		end
	end

	assign res.busy  = tag_s2.valid || done_q;
	assign res.done  = done_q;
	assign res.level = sat_level;

endmodule

// ----- rtl/core/recurrent_net_evaluator_unit.sv -----
// Recurrent network evaluator: N = 2 + INPUT_COUNT + OUTPUT_COUNT + HIDDEN_COUNT nodes.
// Reset: arst_n clears control, then a clearing pass zeroes every word of the weight memory
// while in_ready stays low. Weight and sample beats are accepted whenever the unit is idle.
// The last sample starts an evaluation: an init sweep over the nodes, then per update step
// a MAC pass over all N*N synapses on the one shared multiplier, a drain and a copy/check pass.
// Output beats then follow in order, each held until out_ready takes it.
module recurrent_net_evaluator_unit #(
	parameter int INPUT_COUNT  = rne_pkg::DEF_INPUT_COUNT,
	parameter int OUTPUT_COUNT = rne_pkg::DEF_OUTPUT_COUNT,
	parameter int HIDDEN_COUNT = rne_pkg::DEF_HIDDEN_COUNT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic [5:0]                             dest_node,
	input  logic [5:0]                             source_node,
	input  logic signed [rne_pkg::LEVEL_W-1:0]     data_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rne_pkg::LEVEL_W-1:0]     out_value,
	output logic [rne_pkg::OUT_INDEX_W-1:0]        out_index,
	output logic                                   last_output,
	output logic                                   fired,
	input  logic                                   cfg_write,
	input  logic [rne_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rne_pkg::CFG_W-1:0]              cfg_data
);
	import rne_pkg::*;

	localparam int NODE_COUNT   = 2 + INPUT_COUNT + OUTPUT_COUNT + HIDDEN_COUNT;
	localparam int NW           = $clog2(NODE_COUNT);
	localparam int WDEPTH       = NODE_COUNT * NODE_COUNT;
	localparam int WAW          = $clog2(WDEPTH);
	localparam int FIRST_INPUT  = 2;
	localparam int FIRST_OUTPUT = 2 + INPUT_COUNT;
	localparam int EMIT_COUNT   = (OUTPUT_COUNT < MAX_EMIT) ? OUTPUT_COUNT : MAX_EMIT;
	localparam int SW           = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

	localparam logic [NW-1:0]  LAST_NODE = NW'(NODE_COUNT - 1);
	localparam logic [NW-1:0]  BIAS_IDX  = NW'(1);
	localparam logic [NW-1:0]  IN_LO     = NW'(FIRST_INPUT);
	localparam logic [NW-1:0]  IN_HI     = NW'(FIRST_INPUT + INPUT_COUNT - 1);
	localparam logic [NW-1:0]  OUT_LO    = NW'(FIRST_OUTPUT);
	localparam logic [WAW-1:0] LAST_WADDR = WAW'(WDEPTH - 1);
	localparam logic [WAW-1:0] ROW_LEN    = WAW'(NODE_COUNT);
	localparam logic [SW-1:0]  LAST_SAMPLE = SW'(INPUT_COUNT - 1);
	localparam logic [OUT_INDEX_W-1:0] LAST_EMIT = OUT_INDEX_W'(EMIT_COUNT - 1);

	typedef enum logic [10:0] {
		ST_CLEAR     = 11'b000_0000_0001,
		ST_IDLE      = 11'b000_0000_0010,
		ST_INIT      = 11'b000_0000_0100,
		ST_CHECK     = 11'b000_0000_1000,
		ST_MAC       = 11'b000_0001_0000,
		ST_DRAIN     = 11'b000_0010_0000,
		ST_COPY      = 11'b000_0100_0000,
		ST_COPY_END  = 11'b000_1000_0000,
		ST_EMIT_RD   = 11'b001_0000_0000,
		ST_EMIT_LD   = 11'b010_0000_0000,
		ST_EMIT_WAIT = 11'b100_0000_0000
	} state_t;

	state_t st_q;

	// Configuration registers.
	logic [7:0]                max_cycles_q;
	logic signed [LEVEL_W-1:0] init_level_q;
	logic [14:0]               out_limit_q;
	logic signed [LEVEL_W-1:0] thresh_q;

	// Sequencer counters.
	logic [WAW-1:0]         wa_q;
	logic [NW-1:0]          s_q;
	logic [NW-1:0]          d_q;
	logic [NW-1:0]          wb_d_q;
	logic [7:0]             cycle_q;
	logic [SW-1:0]          sample_q;
	logic [OUT_INDEX_W-1:0] k_q;
	logic signed [LEVEL_W-1:0] trig_q;
	logic                   fired_q;
	logic                   out_valid_q;

	// Memories and their registered read data.
	logic signed [LEVEL_W-1:0] weight_mem [WDEPTH];
	logic signed [LEVEL_W-1:0] node_mem   [NODE_COUNT];
	logic signed [LEVEL_W-1:0] next_mem   [NODE_COUNT];
	logic signed [LEVEL_W-1:0] weight_rd_s1;
	logic signed [LEVEL_W-1:0] node_rd_s1;
	logic signed [LEVEL_W-1:0] next_rd_s1;

	logic                      weight_we;
	logic [WAW-1:0]            weight_wa;
	logic signed [LEVEL_W-1:0] weight_wd;
	logic                      node_we;
	logic [NW-1:0]             node_wa;
	logic signed [LEVEL_W-1:0] node_wd;
	logic [NW-1:0]             node_ra;

	mac_tag_t tag_s1;
	mac_res_t res;
	logic     cp_valid_s1;
	logic [NW-1:0] cp_idx_s1;

	logic in_acc;
	logic addr_ok;
	logic [WAW-1:0] wr_addr;
	logic s_is_input;
	logic cp_is_held;
	logic trig_low;
	logic signed [LEVEL_W:0] lv_ext;
	logic signed [LEVEL_W:0] lim_ext;
	logic signed [LEVEL_W:0] clamped;

	assign in_ready  = (st_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign addr_ok   = (32'(dest_node) < NODE_COUNT) && (32'(source_node) < NODE_COUNT);
	assign wr_addr   = WAW'(dest_node) * ROW_LEN + WAW'(source_node);
	assign s_is_input = (s_q >= IN_LO) && (s_q <= IN_HI);
	assign cp_is_held = (cp_idx_s1 == BIAS_IDX) || ((cp_idx_s1 >= IN_LO) && (cp_idx_s1 <= IN_HI));
	assign trig_low  = (trig_q < thresh_q);

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cycles_q <= RST_MAX_CYCLES;
			init_level_q <= RST_INIT_LEVEL;
			out_limit_q  <= RST_OUT_LIMIT;
			thresh_q     <= RST_TRIG_THRESH;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_CYCLES:        max_cycles_q <= cfg_data[7:0];
				REG_INIT_LEVEL:        init_level_q <= cfg_data;
				REG_OUTPUT_LIMIT:      out_limit_q  <= cfg_data[14:0];
				REG_TRIGGER_THRESHOLD: thresh_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Weight memory write port: zeroing pass after reset, weight beats when idle.
	always_comb begin
		weight_we = 1'b0;
		weight_wa = wa_q;
		weight_wd = '0;
		if (st_q == ST_CLEAR) begin
			weight_we = 1'b1;
		end else if (in_acc && action == ACT_WEIGHT && addr_ok) begin
			weight_we = 1'b1;
			weight_wa = wr_addr;
			weight_wd = data_value;
		end
	end

	// Node memory write port: samples, the start-of-evaluation sweep and the copy sweep.
	always_comb begin
		node_we = 1'b0;
		node_wa = s_q;
		node_wd = init_level_q;
		if (cp_valid_s1) begin
			node_we = !cp_is_held;
			node_wa = cp_idx_s1;
			node_wd = next_rd_s1;
		end else if (st_q == ST_INIT) begin
			node_we = !s_is_input;
			if (s_q == '0) begin
				node_wd = '0;
			end else if (s_q == BIAS_IDX) begin
				node_wd = BIAS_LEVEL;
			end
		end else if (in_acc && action == ACT_SAMPLE) begin
			node_we = 1'b1;
			node_wa = IN_LO + NW'(sample_q);
			node_wd = data_value;
		end
	end

	assign node_ra = (st_q == ST_EMIT_RD) ? (OUT_LO + NW'(k_q)) : s_q;

	always_ff @(posedge clk) begin
		if (weight_we) begin
			weight_mem[weight_wa] <= weight_wd;
		end
		weight_rd_s1 <= weight_mem[wa_q];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_wa] <= node_wd;
		end
		node_rd_s1 <= node_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			next_mem[wb_d_q] <= res.level;
		end
		next_rd_s1 <= next_mem[s_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			cp_valid_s1 <= 1'b0;
			cp_idx_s1   <= '0;
		end else begin
			tag_s1.valid <= (st_q == ST_MAC);
			tag_s1.first <= (s_q == '0);
			tag_s1.last  <= (s_q == LAST_NODE);
			cp_valid_s1  <= (st_q == ST_COPY);
			cp_idx_s1    <= s_q;
		end
	end

	rne_mac #(
		.NODE_COUNT(NODE_COUNT)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.weight_s1 (weight_rd_s1),
		.level_s1  (node_rd_s1),
		.res       (res)
	);

	// Rows finish in order, so the write-back row simply counts finished rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_d_q <= '0;
		end else if (st_q == ST_CHECK) begin
			wb_d_q <= '0;
		end else if (res.done) begin
			wb_d_q <= (wb_d_q == LAST_NODE) ? '0 : wb_d_q + 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			wa_q        <= '0;
			s_q         <= '0;
			d_q         <= '0;
			cycle_q     <= '0;
			sample_q    <= '0;
			k_q         <= '0;
			trig_q      <= '0;
			fired_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					if (wa_q == LAST_WADDR) begin
						wa_q <= '0;
						st_q <= ST_IDLE;
					end else begin
						wa_q <= wa_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_acc && action == ACT_SAMPLE) begin
						if (sample_q == LAST_SAMPLE) begin
							sample_q <= '0;
							s_q      <= '0;
							st_q     <= ST_INIT;
						end else begin
							sample_q <= sample_q + 1'b1;
						end
					end
				end
				ST_INIT: begin
					if (s_q == LAST_NODE) begin
						s_q     <= '0;
						cycle_q <= '0;
						trig_q  <= '0;
						st_q    <= ST_CHECK;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (cycle_q < max_cycles_q && trig_low) begin
						s_q  <= '0;
						d_q  <= '0;
						wa_q <= '0;
						st_q <= ST_MAC;
					end else begin
						fired_q <= !trig_low;
						k_q     <= '0;
						st_q    <= ST_EMIT_RD;
					end
				end
				ST_MAC: begin
					wa_q <= wa_q + 1'b1;
					if (s_q == LAST_NODE) begin
						s_q <= '0;
						if (d_q == LAST_NODE) begin
							d_q  <= '0;
							st_q <= ST_DRAIN;
						end else begin
							d_q <= d_q + 1'b1;
						end
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!tag_s1.valid && !res.busy) begin
						s_q  <= '0;
						st_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (s_q == LAST_NODE) begin
						s_q  <= '0;
						st_q <= ST_COPY_END;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				ST_COPY_END: begin
					cycle_q <= cycle_q + 1'b1;
					st_q    <= ST_CHECK;
				end
				ST_EMIT_RD: begin
					st_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					st_q        <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (k_q == LAST_EMIT) begin
							st_q <= ST_IDLE;
						end else begin
							k_q  <= k_q + 1'b1;
							st_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			// The trigger level follows node 0 as the copy sweep writes it.
			if (cp_valid_s1 && cp_idx_s1 == '0) begin
				trig_q <= next_rd_s1;
			end
		end
	end

	// Output clamp to +-output_limit.
	always_comb begin
		lv_ext  = (LEVEL_W+1)'(node_rd_s1);
		lim_ext = (LEVEL_W+1)'({1'b0, out_limit_q});
		if (lv_ext > lim_ext) begin
			clamped = lim_ext;
		end else if (lv_ext < -lim_ext) begin
			clamped = -lim_ext;
		end else begin
			clamped = lv_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EMIT_LD) begin
			out_value   <= clamped[LEVEL_W-1:0];
			out_index   <= k_q;
			last_output <= (k_q == LAST_EMIT);
			fired       <= fired_q;
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (st_q == ST_MAC || st_q == ST_DRAIN))
		else $error("MAC row result outside the update phase");

	a_all_rows_written: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY && $past(st_q) == ST_DRAIN) |-> (wb_d_q == '0))
		else $error("copy started before every row was written back");

	a_out_only_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (st_q == ST_EMIT_WAIT))
		else $error("output beat offered outside the emit state");

	a_copy_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> (st_q == ST_COPY || st_q == ST_COPY_END))
		else $error("copy write outside the copy sweep");

endmodule

// ----- tb/tb_recurrent_net_evaluator_unit.sv -----
// Testbench for recurrent_net_evaluator_unit: directed and random weight and sample traffic.
// A behavioral model of the network predicts every output beat, and a checker compares in order.
// Depends on rne_pkg and the RTL of recurrent_net_evaluator_unit.
`timescale 1ns / 100ps

module tb_recurrent_net_evaluator_unit;
	import rne_pkg::*;

	localparam int NODES         = 2 + DEF_INPUT_COUNT + DEF_OUTPUT_COUNT + DEF_HIDDEN_COUNT;
	localparam int FIRST_IN      = 2;
	localparam int FIRST_OUT     = 2 + DEF_INPUT_COUNT;
	localparam int EMIT_COUNT    = (DEF_OUTPUT_COUNT < MAX_EMIT) ? DEF_OUTPUT_COUNT : MAX_EMIT;
	localparam int SETTLE_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic signed [LEVEL_W-1:0] value;
		logic [OUT_INDEX_W-1:0]    index;
		logic                      last;
		logic                      fired;
	} node_output_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      action;
	logic [5:0]                dest_node;
	logic [5:0]                source_node;
	logic signed [LEVEL_W-1:0] data_value;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [LEVEL_W-1:0] out_value;
	logic [OUT_INDEX_W-1:0]    out_index;
	logic                      last_output;
	logic                      fired;
	logic                      cfg_write;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;

	// Network model: synapse weights, node levels and the evaluation settings.
	logic signed [LEVEL_W-1:0] weights [NODES*NODES];
	logic signed [LEVEL_W-1:0] levels [NODES];
	int                        samples_taken;
	int                        lim_cycles;
	logic signed [LEVEL_W-1:0] start_level;
	int                        clamp_level;
	logic signed [LEVEL_W-1:0] fire_level;

	node_output_t expected_outputs[$];
	int           errors;
	int           send_idle_pct;
	int           recv_idle_pct;
	longint       cycle_count;

	recurrent_net_evaluator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.dest_node   (dest_node),
		.source_node (source_node),
		.data_value  (data_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.out_index   (out_index),
		.last_output (last_output),
		.fired       (fired),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void reset_model();
		for (int i = 0; i < NODES * NODES; i++)
			weights[i] = '0;
		for (int n = 0; n < NODES; n++)
			levels[n] = '0;
		samples_taken = 0;
		lim_cycles    = int'(RST_MAX_CYCLES);
		start_level   = RST_INIT_LEVEL;
		clamp_level   = int'(RST_OUT_LIMIT);
		fire_level    = RST_TRIG_THRESH;
	endfunction

	function automatic void apply_register(cfg_reg_t idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_MAX_CYCLES:        lim_cycles  = int'(val[7:0]);
			REG_INIT_LEVEL:        start_level = val;
			REG_OUTPUT_LIMIT:      clamp_level = int'(val[14:0]);
			REG_TRIGGER_THRESHOLD: fire_level  = val;
			default: ;
		endcase
	endfunction

	// Q16.16 sum to Q8.8: round half up, then saturate.
	function automatic logic signed [LEVEL_W-1:0] round_q88(longint acc);
		longint q;
		q = (acc + 128) >>> 8;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[LEVEL_W-1:0];
	endfunction

	function automatic bit is_fixed_node(int n);
		return n == 1 || (n >= FIRST_IN && n < FIRST_IN + DEF_INPUT_COUNT);
	endfunction

	function automatic void evaluate_network();
		logic signed [LEVEL_W-1:0] next_level [NODES];
		longint                    acc;
		int                        steps;
		int                        v;
		logic                      hit;
		node_output_t              o;
		for (int n = 0; n < NODES; n++)
			if (n < FIRST_IN || n >= FIRST_IN + DEF_INPUT_COUNT)
				levels[n] = start_level;
		levels[0] = '0;
		levels[1] = BIAS_LEVEL;
		steps = 0;
		while (steps < lim_cycles && levels[0] < fire_level) begin
			for (int d = 0; d < NODES; d++) begin
				acc = 0;
				for (int s = 0; s < NODES; s++)
					acc += longint'(levels[s]) * longint'(weights[d * NODES + s]);
				next_level[d] = round_q88(acc);
			end
			for (int d = 0; d < NODES; d++)
				if (!is_fixed_node(d))
					levels[d] = next_level[d];
			steps++;
		end
		hit = (levels[0] >= fire_level);
		for (int k = 0; k < EMIT_COUNT; k++) begin
			v = levels[FIRST_OUT + k];
			if (v > clamp_level)
				v = clamp_level;
			if (v < -clamp_level)
				v = -clamp_level;
			o.value = v[LEVEL_W-1:0];
			o.index = k[OUT_INDEX_W-1:0];
			o.last  = (k == EMIT_COUNT - 1);
			o.fired = hit;
			expected_outputs.insert(expected_outputs.size(), o);
		end
	endfunction

	function automatic void take_beat(logic act, logic [5:0] dest, logic [5:0] src,
			logic signed [LEVEL_W-1:0] data);
		if (act == ACT_WEIGHT) begin
			if (int'(dest) < NODES && int'(src) < NODES)
				weights[int'(dest) * NODES + int'(src)] = data;
		end else begin
			levels[FIRST_IN + samples_taken] = data;
			if (samples_taken + 1 >= DEF_INPUT_COUNT) begin
				samples_taken = 0;
				evaluate_network();
			end else begin
				samples_taken++;
			end
		end
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows
	// acceptance, with in_valid still high.
	task automatic send_beat(input logic act, input logic [5:0] dest, input logic [5:0] src,
			input logic signed [LEVEL_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		dest_node   <= dest;
		source_node <= src;
		data_value  <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		take_beat(act, dest, src, data);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		apply_register(idx, val);
		@(negedge clk);
	endtask

	// Full weights and extreme samples; the trigger is fed from the bias so that it fires
	// after one update even with the largest cycle limit.
	task automatic test_weight_store_and_fire();
		wait_drained();
		write_reg(REG_MAX_CYCLES, 16'h00FF);
		write_reg(REG_OUTPUT_LIMIT, 16'h7FFF);
		write_reg(REG_TRIGGER_THRESHOLD, 16'h0100);
		send_beat(ACT_WEIGHT, 6'd0, 6'd1, 16'sh0100);
		send_beat(ACT_WEIGHT, 6'(FIRST_OUT), 6'd1, 16'sh7FFF);
		send_beat(ACT_WEIGHT, 6'(FIRST_OUT + 1), 6'(FIRST_IN), 16'sh8000);
		send_beat(ACT_WEIGHT, 6'(FIRST_OUT + 2), 6'(FIRST_IN + 1), 16'sh7FFF);
		// Source 41 would alias onto the bias synapse of the next output if not rejected.
		send_beat(ACT_WEIGHT, 6'(FIRST_OUT + 3), 6'd41, 16'sh03E8);
		send_beat(ACT_WEIGHT, 6'd63, 6'd63, 16'shFFFF);
		send_beat(ACT_WEIGHT, 6'd40, 6'd1, 16'sh02BC);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'sh7FFF);
		send_beat(ACT_SAMPLE, 6'd63, 6'd63, 16'sh8000);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'shFFFF);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'sh5555);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'shAAAA);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'sh0100);
		send_beat(ACT_SAMPLE, 6'd0, 6'd0, 16'shFF00);
	endtask

	// No update runs, so the outputs show the lowest starting level, clamped.
	task automatic test_zero_cycle_limit();
		wait_drained();
		write_reg(REG_MAX_CYCLES, 16'h0000);
		write_reg(REG_INIT_LEVEL, 16'h8000);
		repeat (DEF_INPUT_COUNT)
			send_beat(ACT_SAMPLE, 6'($urandom()), 6'($urandom()), 16'($urandom()));
	endtask

	// The trigger starts at zero, which already meets a negative threshold.
	task automatic test_nonpositive_threshold();
		wait_drained();
		write_reg(REG_MAX_CYCLES, 16'h0020);
		write_reg(REG_TRIGGER_THRESHOLD, 16'h8000);
		write_reg(REG_INIT_LEVEL, 16'h7FFF);
		write_reg(REG_OUTPUT_LIMIT, 16'h0064);
		repeat (DEF_INPUT_COUNT)
			send_beat(ACT_SAMPLE, 6'($urandom()), 6'($urandom()), 16'($urandom()));
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int beat_goal, input int cycles_lo, input int cycles_hi,
			input logic [CFG_W-1:0] limit_word, input logic [CFG_W-1:0] threshold_word);
		int                        sent;
		int                        pick;
		logic [5:0]                dest;
		logic [5:0]                src;
		logic signed [LEVEL_W-1:0] data;
		wait_drained();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_reg(REG_MAX_CYCLES, {8'($urandom()), 8'($urandom_range(cycles_hi, cycles_lo))});
		if ($urandom_range(1) == 1)
			write_reg(REG_INIT_LEVEL, 16'($urandom()));
		else
			write_reg(REG_INIT_LEVEL, 16'($urandom_range(1023)) - 16'd512);
		write_reg(REG_OUTPUT_LIMIT, limit_word);
		write_reg(REG_TRIGGER_THRESHOLD, threshold_word);
		sent = 0;
		while (sent < beat_goal) begin
			pick = $urandom_range(99);
			// Small values keep the recurrence out of saturation most of the time.
			if ($urandom_range(1) == 1)
				data = 16'($urandom());
			else
				data = 16'($urandom_range(1023)) - 16'd512;
			if (pick < 55) begin
				send_beat(ACT_SAMPLE, 6'($urandom()), 6'($urandom()), data);
				sent++;
			end else if (pick < 88) begin
				dest = ($urandom_range(4) == 0) ? 6'd0 : 6'($urandom_range(NODES - 1));
				src  = 6'($urandom_range(NODES - 1));
				send_beat(ACT_WEIGHT, dest, src, data);
				sent++;
			end else begin
				// A weight beat aimed outside the network; it must leave the store alone.
				if ($urandom_range(1) == 1) begin
					dest = 6'($urandom_range(63, NODES));
					src  = 6'($urandom());
				end else begin
					dest = 6'($urandom_range(NODES - 1));
					src  = 6'($urandom_range(63, NODES));
				end
				send_beat(ACT_WEIGHT, dest, src, data);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : output_check
		node_output_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_outputs.size() == 0) begin
				$error("output beat with none expected: out_index %0d out_value %0d",
					out_index, out_value);
				errors++;
			end else begin
				want = expected_outputs.pop_front();
				if (out_value !== want.value) begin
					$error("out_value: expected %0d, got %0d", want.value, out_value);
					errors++;
				end
				if (out_index !== want.index) begin
					$error("out_index: expected %0d, got %0d", want.index, out_index);
					errors++;
				end
				if (last_output !== want.last) begin
					$error("last_output: expected %0b, got %0b", want.last, last_output);
					errors++;
				end
				if (fired !== want.fired) begin
					$error("fired: expected %0b, got %0b", want.fired, fired);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_recurrent_net_evaluator_unit: FAIL");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_WEIGHT;
		dest_node     = '0;
		source_node   = '0;
		data_value    = '0;
		out_ready     = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_MAX_CYCLES;
		cfg_data      = '0;
		errors        = 0;
		cycle_count   = 0;
		send_idle_pct = 31;
		recv_idle_pct = 52;
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_weight_store_and_fire();
		test_zero_cycle_limit();
		test_nonpositive_threshold();
		test_random_traffic(31, 52, 23, 1, 8, 16'($urandom()), 16'($urandom_range(640)) - 16'd128);
		test_random_traffic(52, 31, 23, 1, 6, 16'h8000, 16'($urandom()));
		test_random_traffic(0, 0, 23, 24, 32, 16'($urandom()), 16'h7FFF);
		wait_drained();

		if (errors == 0)
			$display("tb_recurrent_net_evaluator_unit: PASS");
		else
			$display("tb_recurrent_net_evaluator_unit: FAIL");
		$finish;
	end

endmodule
